// ----- rtl/core/ptbp_pkg.sv -----
package ptbp_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int PID_BITS_DEF    = 16;
  localparam int HANDLE_BITS_DEF = 16;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Control part of the search wave that travels down the row of cells.
  typedef struct packed {
    logic       active;
    logic [1:0] req;
    logic       found;
  } wave_ctl_t;

endpackage

// ----- rtl/core/ptbp_if.sv -----
interface ptbp_req_if
  import ptbp_pkg::*;
#(
  parameter int PID_BITS    = PID_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic [PID_BITS-1:0]    pid;
  logic [HANDLE_BITS-1:0] entry_handle;

  modport source (output valid, req_type, pid, entry_handle, input ready);
  modport sink   (input valid, req_type, pid, entry_handle, output ready);
endinterface

interface ptbp_res_if
  import ptbp_pkg::*;
#(
  parameter int PID_BITS    = PID_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int COUNT_BITS  = $clog2(TABLE_DEPTH_DEF + 1)
) ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [HANDLE_BITS-1:0] found_handle;
  logic [PID_BITS-1:0]    largest_pid;
  logic                   table_empty;
  logic [COUNT_BITS-1:0]  entry_count;

  modport source (output valid, status, found_handle, largest_pid, table_empty, entry_count,
                  input ready);
  modport sink   (input valid, status, found_handle, largest_pid, table_empty, entry_count,
                  output ready);
endinterface

// ----- rtl/core/ptbp_cell.sv -----
module ptbp_cell
  import ptbp_pkg::*;
#(
  parameter int PID_BITS    = PID_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int COUNT_BITS  = $clog2(TABLE_DEPTH_DEF + 1),
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  // Tail write for an insert.
  input  logic                   wr_go,
  input  logic [COUNT_BITS-1:0]  wr_index,
  input  logic [PID_BITS-1:0]    wr_pid,
  input  logic [HANDLE_BITS-1:0] wr_handle,
  // Wave from the left neighbour.
  input  wave_ctl_t              wave_ctl_in,
  input  logic [PID_BITS-1:0]    wave_key_in,
  input  logic [HANDLE_BITS-1:0] wave_handle_in,
  input  logic [PID_BITS-1:0]    wave_max_in,
  // Wave to the right neighbour.
  output wave_ctl_t              wave_ctl,
  output logic [PID_BITS-1:0]    wave_key,
  output logic [HANDLE_BITS-1:0] wave_handle,
  output logic [PID_BITS-1:0]    wave_max,
  // Contents of the right neighbour, and its request to be copied leftwards.
  input  logic [PID_BITS-1:0]    right_pid,
  input  logic [HANDLE_BITS-1:0] right_handle,
  input  logic                   right_valid,
  input  logic                   right_pull,
  // Own contents towards the left neighbour.
  output logic [PID_BITS-1:0]    pid,
  output logic [HANDLE_BITS-1:0] handle,
  output logic                   valid,
  output logic                   pull
);

  logic wr_en;
  logic searching;
  logic hit;
  logic keep;

  assign wr_en     = wr_go && (wr_index == COUNT_BITS'(INDEX));
  assign searching = wave_ctl_in.active &&
                     (wave_ctl_in.req == REQ_LOOKUP || wave_ctl_in.req == REQ_REMOVE);
  assign hit       = searching && valid && !wave_ctl_in.found && (pid == wave_key_in);
  // Once the oldest match lies behind the wave, each later entry moves one place left.
  assign pull      = wave_ctl_in.active && wave_ctl_in.req == REQ_REMOVE && wave_ctl_in.found;
  // The entry being removed no longer counts towards the largest id.
  assign keep      = valid && !(hit && wave_ctl_in.req == REQ_REMOVE);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_en) begin
      valid <= 1'b1;
    end else if (right_pull) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pid    <= wr_pid;
      handle <= wr_handle;
    end else if (right_pull) begin
      pid    <= right_pid;
      handle <= right_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_ctl <= '0;
    end else begin
      wave_ctl.active <= wave_ctl_in.active;
      wave_ctl.req    <= wave_ctl_in.req;
      wave_ctl.found  <= wave_ctl_in.found || hit;
    end
  end

  always_ff @(posedge clk) begin
    wave_key    <= wave_key_in;
    wave_handle <= hit ? handle : wave_handle_in;
    wave_max    <= (keep && pid > wave_max_in) ? pid : wave_max_in;
  end

endmodule

// ----- rtl/core/process_table_by_pid.sv -----
// Channel  Role    Payload
// req      sink    req_type, pid, entry_handle
// res      source  status, found_handle, largest_pid, table_empty, entry_count
//
// Every request launches one wave that passes through the row of TABLE_DEPTH cells,
// one cell a cycle, from the launch register through the cells to the pending result
// register, and from there into the output register once that register is free.
// One request is in flight at a time; the next is accepted while the previous result
// still waits in the output register. Reset empties the table at once.
module process_table_by_pid
  import ptbp_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int PID_BITS    = PID_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  ptbp_req_if.sink req,
  ptbp_res_if.source res
);

  localparam int COUNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam logic [COUNT_BITS-1:0] DEPTH_C = COUNT_BITS'(TABLE_DEPTH);

  logic                   accept;
  logic                   busy;
  logic                   ins_full;
  logic                   wr_go;
  logic [COUNT_BITS-1:0]  count;
  logic [COUNT_BITS-1:0]  count_next;

  wave_ctl_t              launch_ctl;
  logic [PID_BITS-1:0]    launch_key;

  wave_ctl_t              ctl_tap    [0:TABLE_DEPTH];
  logic [PID_BITS-1:0]    key_tap    [0:TABLE_DEPTH];
  logic [HANDLE_BITS-1:0] handle_tap [0:TABLE_DEPTH];
  logic [PID_BITS-1:0]    max_tap    [0:TABLE_DEPTH];
  logic [PID_BITS-1:0]    cell_pid    [0:TABLE_DEPTH];
  logic [HANDLE_BITS-1:0] cell_handle [0:TABLE_DEPTH];
  logic                   cell_valid  [0:TABLE_DEPTH];
  logic                   cell_pull   [0:TABLE_DEPTH];

  wave_ctl_t              done_ctl;
  logic                   removed;
  logic [1:0]             status_next;

  logic                   pend_valid;
  logic [1:0]             pend_status;
  logic [HANDLE_BITS-1:0] pend_handle;
  logic [PID_BITS-1:0]    pend_largest;
  logic [COUNT_BITS-1:0]  pend_count;
  logic                   move;

  assign req.ready = !busy;
  assign accept    = req.valid && !busy;
  assign wr_go     = accept && req.req_type == REQ_INSERT && count != DEPTH_C;

  assign ctl_tap[0]    = launch_ctl;
  assign key_tap[0]    = launch_key;
  assign handle_tap[0] = '0;
  assign max_tap[0]    = '0;

  // Past the last cell the table reads as an empty slot.
  assign cell_pid[TABLE_DEPTH]    = '0;
  assign cell_handle[TABLE_DEPTH] = '0;
  assign cell_valid[TABLE_DEPTH]  = 1'b0;

  genvar g;
  for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ptbp_cell #(
      .PID_BITS    (PID_BITS),
      .HANDLE_BITS (HANDLE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .INDEX       (g)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .wr_go          (wr_go),
      .wr_index       (count),
      .wr_pid         (req.pid),
      .wr_handle      (req.entry_handle),
      .wave_ctl_in    (ctl_tap[g]),
      .wave_key_in    (key_tap[g]),
      .wave_handle_in (handle_tap[g]),
      .wave_max_in    (max_tap[g]),
      .wave_ctl       (ctl_tap[g+1]),
      .wave_key       (key_tap[g+1]),
      .wave_handle    (handle_tap[g+1]),
      .wave_max       (max_tap[g+1]),
      .right_pid      (cell_pid[g+1]),
      .right_handle   (cell_handle[g+1]),
      .right_valid    (cell_valid[g+1]),
      .right_pull     (cell_pull[g+1]),
      .pid            (cell_pid[g]),
      .handle         (cell_handle[g]),
      .valid          (cell_valid[g]),
      .pull           (cell_pull[g])
    );
  end

  assign done_ctl = ctl_tap[TABLE_DEPTH];
  assign removed  = done_ctl.active && done_ctl.req == REQ_REMOVE && done_ctl.found;
  // When the wave leaves the row after a removal, the last cell takes the empty slot.
  assign cell_pull[TABLE_DEPTH] = removed;

  always_comb begin
    count_next = count;
    if (wr_go) begin
      count_next = count + COUNT_BITS'(1);
    end else if (removed) begin
      count_next = count - COUNT_BITS'(1);
    end
  end

  always_comb begin
    unique case (done_ctl.req)
      REQ_INSERT: status_next = ins_full ? ST_FULL : ST_OK;
      REQ_LOOKUP: status_next = done_ctl.found ? ST_OK : ST_NOT_FOUND;
      REQ_REMOVE: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          status_next = done_ctl.found ? ST_OK : ST_NOT_FOUND;
        end
      end
      REQ_NOP:    status_next = ST_OK;
      default:    status_next = ST_OK;
    endcase
  end

  assign move = pend_valid && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      count      <= '0;
      launch_ctl <= '0;
      pend_valid <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      count             <= count_next;
      launch_ctl.active <= accept;
      launch_ctl.req    <= req.req_type;
      launch_ctl.found  <= 1'b0;
      if (accept) begin
        busy <= 1'b1;
      end else if (move) begin
        busy <= 1'b0;
      end
      if (done_ctl.active) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      launch_key <= req.pid;
      ins_full   <= req.req_type == REQ_INSERT && count == DEPTH_C;
    end
    if (done_ctl.active) begin
      pend_status  <= status_next;
      pend_handle  <= (done_ctl.req == REQ_LOOKUP && done_ctl.found) ?
                      handle_tap[TABLE_DEPTH] : '0;
      pend_largest <= max_tap[TABLE_DEPTH];
      pend_count   <= count_next;
    end
    if (move) begin
      res.status       <= pend_status;
      res.found_handle <= pend_handle;
      res.largest_pid  <= pend_largest;
      res.table_empty  <= pend_count == '0;
      res.entry_count  <= pend_count;
    end
  end

endmodule
